>>> rtl/pbosc_pkg.sv
// Shared types, constants and helper functions of the polyBLEP oscillator.
// Used by pbosc_ctrl, pbosc_dpath and the top level; depends on nothing.
package pbosc_pkg;

  localparam int PH_W    = 24;
  localparam int FRAC    = 20;
  localparam int SMP_W   = 24;
  localparam int VAL_W   = FRAC + 6;
  localparam int INTEG_W = 32;
  localparam int MA_W    = INTEG_W + 1;
  localparam int MB_W    = VAL_W + 1;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = INTEG_W + 8;
  localparam int QUO_W   = FRAC;
  localparam int CNT_W   = $clog2(QUO_W);
  localparam int MODE_W  = 2;
  localparam int STEP_W  = 3;

  localparam logic [MODE_W-1:0] MODE_SAW   = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_CHOIR = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_GLASS = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_PULSE = MODE_W'(3);

  localparam logic signed [MB_W-1:0] K_LEAK      = MB_W'(419);
  localparam logic signed [MB_W-1:0] K_CHOIR_TRI = MB_W'(1101005);
  localparam logic signed [MB_W-1:0] K_CHOIR_SAW = MB_W'(125829);
  localparam logic signed [MB_W-1:0] K_GLASS_SAW = MB_W'(754975);
  localparam logic signed [MB_W-1:0] K_GLASS_SEC = MB_W'(293601);
  localparam logic signed [MB_W-1:0] K_PULSE     = MB_W'(1310720);

  localparam logic [PH_W-1:0] SHIFT_HALF  = PH_W'(1 << (PH_W - 1));
  localparam logic [PH_W-1:0] SHIFT_PULSE = PH_W'(2684355);

  localparam logic signed [VAL_W-1:0] Q_ONE   = VAL_W'(1 << FRAC);
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((1 << (SMP_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_DIV, ST_SQ, ST_FIN, ST_OP, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    MS_NONE, MS_TT, MS_SQINC, MS_LEAK, MS_TRI, MS_CSAW, MS_SS, MS_GSAW, MS_GSEC, MS_PULSE
  } mul_sel_t;

  typedef enum logic [2:0] {
    PO_NONE, PO_ACC_SAW, PO_INTEG_ADD, PO_INTEG_LEAK, PO_SECOND, PO_ACC_LOAD, PO_ACC_ADD
  } post_t;

  typedef enum logic [1:0] {
    BK_NONE, BK_START, BK_END
  } blep_t;

  typedef struct packed {
    mul_sel_t mul;
    post_t    post;
    logic     last;
  } op_t;

  typedef struct packed {
    logic     accept;
    logic     setup;
    logic     div_step;
    logic     fin;
    logic     second;
    mul_sel_t mul;
    post_t    post;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              need_div;
    logic              div_last;
    logic              out_free;
  } sts_t;

  function automatic op_t op_cmd(input logic [MODE_W-1:0] mode,
                                 input logic [STEP_W-1:0] step);
    op_t r;
    r = '{MS_NONE, PO_NONE, 1'b1};
    case (mode)
      MODE_SAW: begin
        r = '{MS_NONE, PO_ACC_SAW, 1'b1};
      end
      MODE_CHOIR: begin
        case (step)
          3'd0:    r = '{MS_SQINC, PO_NONE, 1'b0};
          3'd1:    r = '{MS_NONE, PO_INTEG_ADD, 1'b0};
          3'd2:    r = '{MS_LEAK, PO_NONE, 1'b0};
          3'd3:    r = '{MS_NONE, PO_INTEG_LEAK, 1'b0};
          3'd4:    r = '{MS_TRI, PO_NONE, 1'b0};
          3'd5:    r = '{MS_CSAW, PO_ACC_LOAD, 1'b0};
          default: r = '{MS_NONE, PO_ACC_ADD, 1'b1};
        endcase
      end
      MODE_GLASS: begin
        case (step)
          3'd0:    r = '{MS_SS, PO_NONE, 1'b0};
          3'd1:    r = '{MS_GSAW, PO_SECOND, 1'b0};
          3'd2:    r = '{MS_GSEC, PO_ACC_LOAD, 1'b0};
          default: r = '{MS_NONE, PO_ACC_ADD, 1'b1};
        endcase
      end
      default: begin
        case (step)
          3'd0:    r = '{MS_PULSE, PO_NONE, 1'b0};
          default: r = '{MS_NONE, PO_ACC_LOAD, 1'b1};
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] p, input int sh);
    logic signed [PROD_W-1:0] bias;
    bias = PROD_W'(1) << (sh - 1);
    return (p + bias) >>> sh;
  endfunction

  function automatic logic signed [INTEG_W-1:0] sat_integ(
      input logic signed [INTEG_W+1:0] x);
    logic [2:0] top;
    top = x[INTEG_W+1:INTEG_W-1];
    if (top == 3'b000 || top == 3'b111) begin
      return x[INTEG_W-1:0];
    end else if (x[INTEG_W+1]) begin
      return {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      return {1'b0, {(INTEG_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/pbosc_ctrl.sv
// Sequencer of the polyBLEP oscillator: steps each beat through accept, setup, divide,
// square, correction, the waveform operations and output. Depends on pbosc_pkg.
module pbosc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pbosc_pkg::sts_t sts,
  output pbosc_pkg::cmd_t cmd
);
  import pbosc_pkg::*;

  state_t             state_r, state_nxt;
  logic               second_r, second_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  op_t                op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      second_r <= 1'b0;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
      step_r   <= step_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    step_nxt   = step_r;
    op         = op_cmd(sts.mode, step_r);
    cmd        = '0;
    cmd.second = second_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          second_nxt = 1'b0;
          state_nxt  = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.need_div ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.mul   = MS_TT;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin = 1'b1;
        if (!second_r && (sts.mode == MODE_CHOIR || sts.mode == MODE_PULSE)) begin
          second_nxt = 1'b1;
          state_nxt  = ST_SETUP;
        end else begin
          step_nxt  = '0;
          state_nxt = ST_OP;
        end
      end
      ST_OP: begin
        cmd.mul  = op.mul;
        cmd.post = op.post;
        if (op.last) begin
          state_nxt = ST_OUT;
        end else begin
          step_nxt = STEP_W'(step_r + 1'b1);
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/pbosc_dpath.sv
// Datapath of the polyBLEP oscillator: phase, integrator, restoring divider,
// shared multiplier, accumulator and output register. Depends on pbosc_pkg.
module pbosc_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pbosc_pkg::MODE_W-1:0]        cfg_wr_data,
  input  logic [pbosc_pkg::PH_W-1:0]          in_phase_increment,
  input  logic                                in_restart,
  input  logic [pbosc_pkg::PH_W-1:0]          in_start_phase,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pbosc_pkg::SMP_W-1:0]  out_sample,
  input  pbosc_pkg::cmd_t                     cmd,
  output pbosc_pkg::sts_t                     sts
);
  import pbosc_pkg::*;

  logic [MODE_W-1:0]          mode_r, mode_nxt;
  logic [PH_W-1:0]            ph_r, ph_nxt;
  logic signed [INTEG_W-1:0]  integ_r, integ_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [PH_W-1:0]            inc_r, inc_nxt;
  logic signed [VAL_W-1:0]    v_r, v_nxt;
  blep_t                      kind_r, kind_nxt;
  logic [PH_W-1:0]            rem_r, rem_nxt;
  logic [QUO_W-1:0]           quo_r, quo_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [VAL_W-1:0]    saw_a_r, saw_a_nxt;
  logic signed [VAL_W-1:0]    saw_b_r, saw_b_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [SMP_W-1:0]    out_data_r, out_data_nxt;

  logic [PH_W-1:0]            ph_sel;
  logic                       c_start, c_end;
  logic [PH_W:0]              ph_neg, end_lim;
  logic [PH_W:0]              rem_sh;
  logic                       ge;
  logic signed [VAL_W:0]      sq;
  logic signed [MA_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]   r20, r22;
  logic signed [VAL_W-1:0]    t_v, tt_v, corr;
  logic signed [INTEG_W+1:0]  integ_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SAW;
      ph_r        <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      ph_r        <= ph_nxt;
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inc_r      <= inc_nxt;
    v_r        <= v_nxt;
    kind_r     <= kind_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    prod_r     <= prod_nxt;
    saw_a_r    <= saw_a_nxt;
    saw_b_r    <= saw_b_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign ph_sel  = cmd.second ? PH_W'(ph_r + ((mode_r == MODE_CHOIR) ? SHIFT_HALF : SHIFT_PULSE))
                              : ph_r;
  assign c_start = (ph_sel < inc_r);
  assign end_lim = {1'b1, {PH_W{1'b0}}} - {1'b0, inc_r};
  assign c_end   = ({1'b0, ph_sel} > end_lim);
  assign ph_neg  = {1'b1, {PH_W{1'b0}}} - {1'b0, ph_sel};

  assign rem_sh = {rem_r, 1'b0};
  assign ge     = (rem_sh >= {1'b0, inc_r});

  assign sq  = VAL_W'(0) + (VAL_W+1)'(saw_a_r) - (VAL_W+1)'(saw_b_r);
  assign r20 = round_shift(prod_r, FRAC);
  assign r22 = round_shift(prod_r, PH_W - 2);

  assign t_v  = $signed({{(VAL_W-QUO_W){1'b0}}, quo_r});
  assign tt_v = VAL_W'(r20);

  always_comb begin
    case (kind_r)
      BK_START: corr = (t_v <<< 1) - tt_v - Q_ONE;
      BK_END:   corr = tt_v - (t_v <<< 1) + Q_ONE;
      default:  corr = '0;
    endcase
  end

  always_comb begin
    case (cmd.mul)
      MS_TT:    begin mul_a = MA_W'(quo_r);   mul_b = MB_W'(quo_r);        end
      MS_SQINC: begin mul_a = MA_W'(sq);      mul_b = MB_W'(inc_r);        end
      MS_LEAK:  begin mul_a = MA_W'(integ_r); mul_b = K_LEAK;              end
      MS_TRI:   begin mul_a = MA_W'(integ_r); mul_b = K_CHOIR_TRI;         end
      MS_CSAW:  begin mul_a = MA_W'(saw_a_r); mul_b = K_CHOIR_SAW;         end
      MS_SS:    begin mul_a = MA_W'(saw_a_r); mul_b = MB_W'(saw_a_r);      end
      MS_GSAW:  begin mul_a = MA_W'(saw_a_r); mul_b = K_GLASS_SAW;         end
      MS_GSEC:  begin mul_a = MA_W'(saw_b_r); mul_b = K_GLASS_SEC;         end
      MS_PULSE: begin mul_a = MA_W'(sq);      mul_b = K_PULSE;             end
      default:  begin mul_a = '0;             mul_b = '0;                  end
    endcase
  end

  always_comb begin
    mode_nxt      = mode_r;
    ph_nxt        = ph_r;
    integ_nxt     = integ_r;
    inc_nxt       = inc_r;
    v_nxt         = v_r;
    kind_nxt      = kind_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    saw_a_nxt     = saw_a_r;
    saw_b_nxt     = saw_b_r;
    acc_nxt       = acc_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    integ_sum     = '0;

    if (cfg_wr_en) begin
      mode_nxt = cfg_wr_data;
    end

    if (cmd.accept) begin
      ph_nxt  = PH_W'((in_restart ? in_start_phase : ph_r) + in_phase_increment);
      inc_nxt = in_phase_increment;
      if (in_restart) begin
        integ_nxt = '0;
      end
    end

    if (cmd.setup) begin
      v_nxt    = $signed(VAL_W'(ph_sel[PH_W-1:PH_W-FRAC-1])) - Q_ONE;
      kind_nxt = c_start ? BK_START : (c_end ? BK_END : BK_NONE);
      rem_nxt  = c_start ? ph_sel : PH_W'(ph_neg);
      quo_nxt  = '0;
      cnt_nxt  = '0;
    end

    if (cmd.div_step) begin
      rem_nxt = ge ? PH_W'(rem_sh - {1'b0, inc_r}) : PH_W'(rem_sh);
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end

    if (cmd.fin) begin
      if (cmd.second) begin
        saw_b_nxt = v_r - corr;
      end else begin
        saw_a_nxt = v_r - corr;
      end
    end

    if (cmd.mul != MS_NONE) begin
      prod_nxt = mul_a * mul_b;
    end

    case (cmd.post)
      PO_ACC_SAW: begin
        acc_nxt = ACC_W'(saw_a_r);
      end
      PO_INTEG_ADD: begin
        integ_sum = (INTEG_W+2)'(integ_r) + (INTEG_W+2)'(r22);
        integ_nxt = sat_integ(integ_sum);
      end
      PO_INTEG_LEAK: begin
        integ_sum = (INTEG_W+2)'(integ_r) - (INTEG_W+2)'(r20);
        integ_nxt = sat_integ(integ_sum);
      end
      PO_SECOND: begin
        saw_b_nxt = VAL_W'(r20 <<< 1) - Q_ONE;
      end
      PO_ACC_LOAD: begin
        acc_nxt = ACC_W'(r20);
      end
      PO_ACC_ADD: begin
        acc_nxt = acc_r + ACC_W'(r20);
      end
      default: begin
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      if (acc_r > OUT_MAX) begin
        out_data_nxt = SMP_W'(OUT_MAX);
      end else if (acc_r < OUT_MIN) begin
        out_data_nxt = SMP_W'(OUT_MIN);
      end else begin
        out_data_nxt = SMP_W'(acc_r);
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign sts.mode     = mode_r;
  assign sts.need_div = c_start || c_end;
  assign sts.div_last = (cnt_r == CNT_W'(QUO_W - 1));
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid  = out_valid_r;
  assign out_sample = out_data_r;

endmodule

>>> rtl/polyblep_multi_wave_oscillator_core.sv
// Top level of the polyBLEP multi-waveform oscillator: sequencer plus datapath.
// Depends on pbosc_pkg, pbosc_ctrl and pbosc_dpath.
//
// One input beat (phase increment, restart, start phase) gives one output sample,
// signed with 20 fraction bits and saturated to +/-8. The block works on one beat
// at a time. A beat passes through an accept step, a setup and a finish step for
// each saw evaluation (one, or two in the choir and pulse modes), for each
// evaluation that needs a polyBLEP correction a 20-bit restoring divide of phase
// over increment and one pass through the shared 33x27 multiplier, one to seven
// waveform steps (saw 1, pulse 2, glass 4, choir 7) and an output step, where a
// finished sample waits while the output still holds a stalled sample. The next
// beat is taken while a finished sample waits on the output. The user must write
// waveform_mode through cfg_wr_en/cfg_wr_data only while idle; the block itself
// does not enforce this.
module polyblep_multi_wave_oscillator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pbosc_pkg::MODE_W-1:0]        cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pbosc_pkg::PH_W-1:0]          in_phase_increment,
  input  logic                                in_restart,
  input  logic [pbosc_pkg::PH_W-1:0]          in_start_phase,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pbosc_pkg::SMP_W-1:0]  out_sample
);
  import pbosc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pbosc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbosc_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_phase_increment (in_phase_increment),
    .in_restart         (in_restart),
    .in_start_phase     (in_start_phase),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample         (out_sample),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

>>> sim/tb.sv
// Testbench for polyblep_multi_wave_oscillator_core: phase ticks in, one sample out per tick.
// Predicts each sample in integer arithmetic, checks it in order, and covers all modes.
// Depends on pbosc_pkg (widths and waveform mode codes) and the RTL under rtl/.
`timescale 1ns / 100ps

module tb;
  import pbosc_pkg::*;

  localparam int     SAMPLE_FB      = 20;
  localparam longint PH_ONE         = longint'(1) << PH_W;
  localparam longint PH_MASK        = PH_ONE - 1;
  localparam longint Q_UNIT         = longint'(1) << SAMPLE_FB;
  localparam longint LEAK_Q         = ((longint'(4) << SAMPLE_FB) + 5000) / 10000;
  localparam longint TRI_GAIN_Q     = ((longint'(105) << SAMPLE_FB) + 50) / 100;
  localparam longint CHOIR_SAW_Q    = ((longint'(12) << SAMPLE_FB) + 50) / 100;
  localparam longint GLASS_SAW_Q    = ((longint'(72) << SAMPLE_FB) + 50) / 100;
  localparam longint GLASS_SEC_Q    = ((longint'(28) << SAMPLE_FB) + 50) / 100;
  localparam longint PULSE_GAIN_Q   = ((longint'(125) << SAMPLE_FB) + 50) / 100;
  localparam longint HALF_OFFSET    = PH_ONE >> 1;
  localparam longint PULSE_OFFSET   = ((longint'(16) << PH_W) + 50) / 100;
  localparam longint LEVEL_MAX      = 64'sd2147483647;
  localparam longint LEVEL_MIN      = -64'sd2147483648;
  localparam longint SAMPLE_MAX     = (longint'(8) << SAMPLE_FB) - 1;
  localparam longint SAMPLE_MIN     = -(longint'(8) << SAMPLE_FB);
  localparam int     WATCHDOG_LIMIT = 5000;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [MODE_W-1:0]        cfg_wr_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [PH_W-1:0]          in_phase_increment;
  logic                     in_restart;
  logic [PH_W-1:0]          in_start_phase;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [SMP_W-1:0]  out_sample;

  logic signed [SMP_W-1:0]  expected_samples[$];
  logic signed [SMP_W-1:0]  sample_due;
  longint                   phase_acc;
  longint                   choir_level;
  logic [MODE_W-1:0]        wave_mode;
  bit                       idle_bursts;
  int                       mismatch_count;
  int                       quiet_cycles;

  polyblep_multi_wave_oscillator_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_phase_increment (in_phase_increment),
    .in_restart         (in_restart),
    .in_start_phase     (in_start_phase),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample         (out_sample)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint fix_mul(input longint a, input longint b);
    return (a * b + (longint'(1) << (SAMPLE_FB - 1))) >>> SAMPLE_FB;
  endfunction

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic longint corrected_saw(input longint ph, input longint inc);
    longint v;
    longint t;
    v = ((ph << (SAMPLE_FB + 1)) >>> PH_W) - Q_UNIT;
    if (ph < inc) begin
      t = (ph << SAMPLE_FB) / inc;
      v = v - (2 * t - fix_mul(t, t) - Q_UNIT);
    end else if (ph > PH_ONE - inc) begin
      t = ((PH_ONE - ph) << SAMPLE_FB) / inc;
      v = v - (fix_mul(t, t) - 2 * t + Q_UNIT);
    end
    return v;
  endfunction

  // advance the oscillator copy by one tick and return its sample
  function automatic logic signed [SMP_W-1:0] predict_sample(input logic [PH_W-1:0] inc_in,
                                                             input logic rs,
                                                             input logic [PH_W-1:0] sp);
    longint inc;
    longint saw;
    longint res;
    longint lvl;
    longint diff;
    longint second;
    inc = longint'(inc_in);
    if (rs) begin
      phase_acc   = longint'(sp);
      choir_level = 0;
    end
    phase_acc = (phase_acc + inc) & PH_MASK;
    saw = corrected_saw(phase_acc, inc);
    case (wave_mode)
      MODE_CHOIR: begin
        diff = saw - corrected_saw((phase_acc + HALF_OFFSET) & PH_MASK, inc);
        lvl = choir_level + ((diff * inc + (longint'(1) << (PH_W - 3))) >>> (PH_W - 2));
        lvl = clip(lvl, LEVEL_MIN, LEVEL_MAX);
        lvl = lvl - fix_mul(lvl, LEAK_Q);
        lvl = clip(lvl, LEVEL_MIN, LEVEL_MAX);
        choir_level = lvl;
        res = fix_mul(TRI_GAIN_Q, lvl) + fix_mul(CHOIR_SAW_Q, saw);
      end
      MODE_GLASS: begin
        second = 2 * fix_mul(saw, saw) - Q_UNIT;
        res = fix_mul(GLASS_SAW_Q, saw) + fix_mul(GLASS_SEC_Q, second);
      end
      MODE_PULSE: begin
        diff = saw - corrected_saw((phase_acc + PULSE_OFFSET) & PH_MASK, inc);
        res = fix_mul(PULSE_GAIN_Q, diff);
      end
      default: begin
        res = saw;
      end
    endcase
    res = clip(res, SAMPLE_MIN, SAMPLE_MAX);
    return res[SMP_W-1:0];
  endfunction

  function automatic logic [MODE_W-1:0] mode_by_index(input int k);
    case (k)
      0:       return MODE_SAW;
      1:       return MODE_PULSE;
      2:       return MODE_CHOIR;
      default: return MODE_GLASS;
    endcase
  endfunction

  function automatic logic [PH_W-1:0] pick_increment();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      return PH_W'($urandom_range(1, 32'hFFFF));
    end else if (sel < 55) begin
      return PH_W'($urandom_range(1, 32'h800000));
    end else if (sel < 65) begin
      return PH_W'($urandom_range(32'h800001, 32'hFFFFFF));
    end else if (sel < 70) begin
      return '0;
    end else if (sel < 80) begin
      case ($urandom_range(0, 4))
        0:       return PH_W'(1);
        1:       return PH_W'(24'hFFFFFF);
        2:       return PH_W'(24'h800000);
        3:       return PH_W'(24'h800001);
        default: return PH_W'(24'h7FFFFF);
      endcase
    end
    return PH_W'($urandom);
  endfunction

  function automatic logic [PH_W-1:0] pick_start();
    case ($urandom_range(0, 3))
      0:       return PH_W'($urandom_range(0, 255));
      1:       return PH_W'(32'hFFFFFF - $urandom_range(0, 255));
      default: return PH_W'($urandom);
    endcase
  endfunction

  task automatic send_tick(input logic [PH_W-1:0] inc, input logic rs,
                           input logic [PH_W-1:0] sp);
    if (idle_bursts && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_phase_increment <= inc;
    in_restart         <= rs;
    in_start_phase     <= sp;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_samples.push_back(predict_sample(inc, rs, sp));
  endtask

  // drain the block, then write the mode register
  task automatic write_mode(input logic [MODE_W-1:0] m);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    wave_mode = m;
  endtask

  task automatic test_directed_edges();
    int k;
    idle_bursts = 1'b1;
    for (k = 0; k < 4; k++) begin
      write_mode(mode_by_index(k));
      send_tick(PH_W'(1), 1'b1, '0);
      send_tick('0, 1'b0, PH_W'(24'h5A5A5A));
      send_tick(PH_W'(24'hFFFFFF), 1'b0, '0);
      send_tick(PH_W'(24'h800000), 1'b1, PH_W'(24'hFFFFFF));
      send_tick(PH_W'(8), 1'b1, PH_W'(24'hFFFFF0));
      send_tick(PH_W'(24'hFFFFFF), 1'b1, PH_W'(24'hFFFFFF));
    end
  endtask

  // hold the phase nearly still so the choir integrator ramps hard up, then down
  task automatic test_integrator_saturation();
    int k;
    idle_bursts = 1'b1;
    write_mode(MODE_CHOIR);
    send_tick(PH_W'(24'hFFFFFF), 1'b1, PH_W'(24'hFFFF00));
    for (k = 0; k < 120; k++) begin
      send_tick(PH_W'(32'hFFFFFF - $urandom_range(0, 15)), 1'b0, pick_start());
    end
    send_tick(PH_W'(24'hFFFFFF), 1'b1, PH_W'(24'h7FFF00));
    for (k = 0; k < 120; k++) begin
      send_tick(PH_W'(32'hFFFFFF - $urandom_range(0, 15)), 1'b0, pick_start());
    end
  endtask

  task automatic test_random_mix(input int phases, input int per_phase, input bit with_idle);
    int p;
    int k;
    idle_bursts = with_idle;
    for (p = 0; p < phases; p++) begin
      write_mode(mode_by_index((p < 4) ? p : $urandom_range(0, 3)));
      for (k = 0; k < per_phase; k++) begin
        send_tick(pick_increment(), ($urandom_range(0, 9) == 0), pick_start());
      end
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_bursts && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_samples.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected sample: expected none actual %0d", $time, out_sample);
      end else begin
        sample_due = expected_samples.pop_front();
        if (out_sample !== sample_due) begin
          mismatch_count++;
          $display("%0t sample mismatch: expected %0d actual %0d",
                   $time, sample_due, out_sample);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = MODE_SAW;
    in_valid           = 1'b0;
    in_phase_increment = '0;
    in_restart         = 1'b0;
    in_start_phase     = '0;
    phase_acc          = 0;
    choir_level        = 0;
    wave_mode          = MODE_SAW;
    idle_bursts        = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_integrator_saturation();
    test_random_mix(6, 70, 1'b1);
    test_random_mix(2, 60, 1'b0);

    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
